@@ src/ngbc_pkg.sv @@
package ngbc_pkg;

    // field and register widths
    localparam int BYTE_W     = 8;
    localparam int NIB_W      = 4;
    localparam int GRID_CELLS = 16;
    localparam int KEY_W      = NIB_W * GRID_CELLS;
    localparam int IV_W       = 32;
    localparam int BUS_W      = 64;
    localparam int ADDR_W     = 5;

    // reset value of the chain start block
    localparam logic [IV_W-1:0] IV_RESET = 32'h6aa2_9ebe;

    // default chain block length in bytes
    localparam int BLOCK_BYTES_DEF = 4;

    // configuration register slots, one per 8-byte word
    typedef enum logic [1:0] {
        REG_KEY_GRID    = 2'd0,
        REG_DECRYPT     = 2'd1,
        REG_CHAINING    = 2'd2,
        REG_INIT_VECTOR = 2'd3
    } t_reg_idx;

    // grid entry at a row-major index
    function automatic logic [NIB_W-1:0] nib_at(input logic [KEY_W-1:0] grid,
                                                input logic [3:0] idx);
        return grid[{idx, 2'b00} +: NIB_W];
    endfunction

endpackage

@@ src/nibble_grid_byte_cipher_cbc_core.sv @@
// channel   | valid    | stall    | payload
// ----------+----------+----------+-----------------------------------
// input     | i_valid  | o_stall  | i_data_byte, i_first_of_message
// output    | o_valid  | i_stall  | o_result_byte, o_bad_key
// config    | APB write when psel, penable, pwrite, pready all high
//
// one byte per clock while o_stall is low; a result is registered in the output register,
// or in the skid entry when that is held. the per-byte path is the grid inverse lookup and
// substitution in ngbc_subst, and the chain byte read/write at the block position, all in the transfer cycle.
// reset (i_rst_n low, synchronous) restores register defaults and reloads the
// chain from the default init vector.
// the output side holds a result register and one skid entry; o_stall rises
// only when both are full.
module nibble_grid_byte_cipher_cbc_core
    import ngbc_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_first_of_message,
    // output channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_result_byte,
    output logic              o_bad_key,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [BUS_W-1:0]  pwdata,
    output logic [BUS_W-1:0]  prdata,
    output logic              pready
);

    localparam int POS_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

    // configuration registers
    logic [KEY_W-1:0] r_key_grid;
    logic             r_decrypt;
    logic             r_chaining;
    logic [IV_W-1:0]  r_iv;

    // chain state
    logic [BYTE_W-1:0] r_chain [BLOCK_BYTES];
    logic [POS_W-1:0]  r_pos;

    // output register and skid entry
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_bad;
    logic              r_skid_valid;
    logic [BYTE_W-1:0] r_skid_byte;
    logic              r_skid_bad;

    logic              cfg_wr;
    t_reg_idx          cfg_idx;
    logic              in_xfer;
    logic              out_xfer;
    logic [POS_W-1:0]  pos_eff;
    logic [POS_W-1:0]  n_pos;
    logic [BYTE_W-1:0] cprev;
    logic [BYTE_W-1:0] sub_in;
    logic [BYTE_W-1:0] sub_out;
    logic              key_ok;
    logic [BYTE_W-1:0] res_byte;
    logic [BYTE_W-1:0] chain_new;

    // config port decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);

    always_comb begin
        unique case (cfg_idx)
            REG_KEY_GRID:    prdata = r_key_grid;
            REG_DECRYPT:     prdata = BUS_W'(r_decrypt);
            REG_CHAINING:    prdata = BUS_W'(r_chaining);
            REG_INIT_VECTOR: prdata = BUS_W'(r_iv);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_grid <= '0;
            r_decrypt  <= 1'b0;
            r_chaining <= 1'b0;
            r_iv       <= IV_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KEY_GRID:    r_key_grid <= pwdata[KEY_W-1:0];
                REG_DECRYPT:     r_decrypt  <= pwdata[0];
                REG_CHAINING:    r_chaining <= pwdata[0];
                REG_INIT_VECTOR: r_iv       <= pwdata[IV_W-1:0];
                default:         ;
            endcase
        end
    end

    // handshakes
    assign o_stall  = r_skid_valid;
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;

    // chain byte for this transfer, reloaded from the init vector on first
    assign pos_eff = i_first_of_message ? '0 : r_pos;
    assign cprev   = i_first_of_message ? r_iv[IV_W-1 -: BYTE_W] : r_chain[r_pos];

    assign sub_in = (r_chaining && !r_decrypt) ? (i_data_byte ^ cprev) : i_data_byte;

    ngbc_subst u_subst (
        .i_key_grid (r_key_grid),
        .i_byte     (sub_in),
        .i_decrypt  (r_decrypt),
        .o_byte     (sub_out),
        .o_key_ok   (key_ok)
    );

    // result, zero on a bad key
    always_comb begin
        if (!key_ok) begin
            res_byte = '0;
        end else if (r_chaining && r_decrypt) begin
            res_byte = sub_out ^ cprev;
        end else begin
            res_byte = sub_out;
        end
    end

    // ciphertext feeds the chain in both directions
    assign chain_new = r_decrypt ? i_data_byte : res_byte;

    // next block position
    always_comb begin
        if (r_chaining) begin
            n_pos = (pos_eff == POS_W'(BLOCK_BYTES - 1)) ? '0 : POS_W'(pos_eff + 1'b1);
        end else begin
            n_pos = pos_eff;
        end
    end

    // chain block and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BLOCK_BYTES; i++) begin
                r_chain[i] <= IV_RESET[BYTE_W*(3 - (i % 4)) +: BYTE_W];
            end
            r_pos <= '0;
        end else if (in_xfer) begin
            // current byte takes the new chain byte, the rest reload on first
            for (int i = 0; i < BLOCK_BYTES; i++) begin
                if (r_chaining && (POS_W'(i) == pos_eff)) begin
                    r_chain[i] <= chain_new;
                end else if (i_first_of_message) begin
                    r_chain[i] <= r_iv[BYTE_W*(3 - (i % 4)) +: BYTE_W];
                end
            end
            r_pos <= n_pos;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_byte <= r_skid_byte;
                r_out_bad  <= r_skid_bad;
            end else if (in_xfer) begin
                r_out_byte <= res_byte;
                r_out_bad  <= !key_ok;
            end
        end else if (in_xfer) begin
            r_skid_byte <= res_byte;
            r_skid_bad  <= !key_ok;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_byte = r_out_byte;
    assign o_bad_key     = r_out_bad;

    // checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    a_pos_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(BLOCK_BYTES - 1))
        else $error("block position beyond block length");

    a_plain_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !r_chaining && !i_first_of_message) |=> $stable(r_pos))
        else $error("block position moved in plain mode");

    a_bad_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_key) |-> (o_result_byte == '0))
        else $error("nonzero result with a bad key");

endmodule

@@ src/ngbc_subst.sv @@
module ngbc_subst
    import ngbc_pkg::*;
(
    input  logic [KEY_W-1:0]  i_key_grid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_decrypt,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_key_ok
);

    logic [3:0]            a_idx;
    logic [3:0]            b_idx;
    logic [GRID_CELLS-1:0] seen;
    logic [NIB_W-1:0]      nib_a;
    logic [NIB_W-1:0]      nib_b;
    logic [1:0]            a_row, a_col, b_row, b_col;
    logic [1:0]            step;
    logic [3:0]            na_idx;
    logic [3:0]            nb_idx;

    assign nib_a = i_byte[BYTE_W-1 -: NIB_W];
    assign nib_b = i_byte[NIB_W-1:0];

    // inverse lookup: lowest grid index holding each nibble, plus coverage
    always_comb begin
        a_idx = '0;
        b_idx = '0;
        seen  = '0;
        for (int k = GRID_CELLS - 1; k >= 0; k--) begin
            if (nib_at(i_key_grid, 4'(k)) == nib_a) begin
                a_idx = 4'(k);
            end
            if (nib_at(i_key_grid, 4'(k)) == nib_b) begin
                b_idx = 4'(k);
            end
            seen = seen | (GRID_CELLS'(1) << nib_at(i_key_grid, 4'(k)));
        end
    end

    assign o_key_ok = &seen;

    assign a_row = a_idx[3:2];
    assign a_col = a_idx[1:0];
    assign b_row = b_idx[3:2];
    assign b_col = b_idx[1:0];
    assign step  = i_decrypt ? 2'd3 : 2'd1;

    // same row shifts columns, same column shifts rows, else swap corners
    always_comb begin
        priority if (a_row == b_row) begin
            na_idx = {a_row, 2'(a_col + step)};
            nb_idx = {b_row, 2'(b_col + step)};
        end else if (a_col == b_col) begin
            na_idx = {2'(a_row + step), a_col};
            nb_idx = {2'(b_row + step), b_col};
        end else begin
            na_idx = {a_row, b_col};
            nb_idx = {b_row, a_col};
        end
    end

    assign o_byte = {nib_at(i_key_grid, na_idx), nib_at(i_key_grid, nb_idx)};

endmodule

@@ tb/sv/cipher_result_checker.sv @@
module cipher_result_checker
    import ngbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_first_of_message,
    // output channel
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [BYTE_W-1:0] i_result_byte,
    input  logic              i_bad_key,
    // configuration port
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [BUS_W-1:0]  i_pwdata,
    input  logic              i_pready,
    // status for the top
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAIN_LEN = BLOCK_BYTES_DEF;

    typedef struct packed {
        logic              bad;
        logic [BYTE_W-1:0] value;
    } t_cipher_result;

    // shadow of the configuration registers
    logic [KEY_W-1:0]  key_grid_q;
    logic              decrypt_q;
    logic              chaining_q;
    logic [IV_W-1:0]   init_vector_q;

    // shadow of the chain state
    logic [BYTE_W-1:0] chain_bytes [CHAIN_LEN];
    int                chain_pos;

    t_cipher_result    expected_results [$];
    int                fail_total = 0;

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_total++;
    endtask

    // chain restart from the init vector, msb byte first
    task automatic reload_chain();
        int i;
        for (i = 0; i < CHAIN_LEN; i++) begin
            chain_bytes[i] = init_vector_q[8*(3-(i%4)) +: 8];
        end
        chain_pos = 0;
    endtask

    // nibble grid substitution: returns {missing-nibble flag, substituted byte}
    function automatic logic [8:0] grid_substitute(input logic [KEY_W-1:0] grid,
                                                   input logic [BYTE_W-1:0] din,
                                                   input logic inverse);
        int where_of [GRID_CELLS];
        bit seen [GRID_CELLS];
        bit missing;
        int k, v, ak, bk, ar, ac, br, bc, step;
        logic [NIB_W-1:0] na, nb;
        missing = 1'b0;
        for (v = 0; v < GRID_CELLS; v++) begin
            where_of[v] = 0;
            seen[v] = 1'b0;
        end
        // scan downward so a repeated nibble ends at its lowest index
        for (k = GRID_CELLS - 1; k >= 0; k--) begin
            where_of[grid[4*k +: 4]] = k;
            seen[grid[4*k +: 4]] = 1'b1;
        end
        for (v = 0; v < GRID_CELLS; v++) begin
            if (!seen[v]) missing = 1'b1;
        end
        ak = where_of[din[7:4]];
        bk = where_of[din[3:0]];
        ar = ak / 4;
        ac = ak % 4;
        br = bk / 4;
        bc = bk % 4;
        step = inverse ? 3 : 1;
        if (ar == br) begin
            // same row, equal nibbles included
            na = grid[4*(ar*4 + (ac + step) % 4) +: 4];
            nb = grid[4*(br*4 + (bc + step) % 4) +: 4];
        end else if (ac == bc) begin
            na = grid[4*(((ar + step) % 4)*4 + ac) +: 4];
            nb = grid[4*(((br + step) % 4)*4 + bc) +: 4];
        end else begin
            // rectangle corners swap
            na = grid[4*(ar*4 + bc) +: 4];
            nb = grid[4*(br*4 + ac) +: 4];
        end
        return {missing, na, nb};
    endfunction

    // track transfers, predict and compare
    always @(posedge i_clk) begin : track
        t_cipher_result    want;
        logic [8:0]        sub;
        logic [BYTE_W-1:0] prev;
        logic [BYTE_W-1:0] res;
        if (!i_rst_n) begin
            key_grid_q    = '0;
            decrypt_q     = 1'b0;
            chaining_q    = 1'b0;
            init_vector_q = IV_RESET;
            reload_chain();
            expected_results.delete();
        end else begin
            // output transfer against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", int'(i_result_byte), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_result_byte !== want.value)
                        report_mismatch("result_byte", int'(i_result_byte), int'(want.value));
                    if (i_bad_key !== want.bad)
                        report_mismatch("bad_key", int'(i_bad_key), int'(want.bad));
                end
            end
            // input transfer
            if (i_in_valid && !i_in_stall) begin
                if (i_first_of_message) reload_chain();
                if (chaining_q) begin
                    prev = chain_bytes[chain_pos];
                    if (decrypt_q) begin
                        sub = grid_substitute(key_grid_q, i_data_byte, 1'b1);
                        res = sub[8] ? '0 : (sub[7:0] ^ prev);
                        chain_bytes[chain_pos] = i_data_byte;
                    end else begin
                        sub = grid_substitute(key_grid_q, i_data_byte ^ prev, 1'b0);
                        res = sub[8] ? '0 : sub[7:0];
                        chain_bytes[chain_pos] = res;
                    end
                    chain_pos = (chain_pos + 1) % CHAIN_LEN;
                end else begin
                    // plain mode leaves the chain alone
                    sub = grid_substitute(key_grid_q, i_data_byte, decrypt_q);
                    res = sub[8] ? '0 : sub[7:0];
                end
                expected_results.push_back({sub[8], res});
            end
            // register write; the chain is not reloaded here
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                unique case (t_reg_idx'(i_paddr[4:3]))
                    REG_KEY_GRID:    key_grid_q    = i_pwdata;
                    REG_DECRYPT:     decrypt_q     = i_pwdata[0];
                    REG_CHAINING:    chaining_q    = i_pwdata[0];
                    REG_INIT_VECTOR: init_vector_q = i_pwdata[IV_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ngbc_pkg::*;

    localparam int QUIET_LIMIT     = 1000;
    localparam int ITEMS_PER_PHASE = 555;
    localparam int HOLD_CYCLES     = 80;
    localparam logic [KEY_W-1:0] GRID_IDENTITY = 64'hfedc_ba98_7654_3210;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [BYTE_W-1:0] i_data_byte;
    logic              i_first_of_message;
    logic              o_valid;
    logic              i_stall;
    logic [BYTE_W-1:0] o_result_byte;
    logic              o_bad_key;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [BUS_W-1:0]  pwdata;
    logic [BUS_W-1:0]  prdata;
    logic              pready;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;

    nibble_grid_byte_cipher_cbc_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_byte        (i_data_byte),
        .i_first_of_message (i_first_of_message),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_result_byte      (o_result_byte),
        .o_bad_key          (o_bad_key),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    cipher_result_checker u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_data_byte        (i_data_byte),
        .i_first_of_message (i_first_of_message),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_result_byte      (o_result_byte),
        .i_bad_key          (o_bad_key),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_pready           (pready),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stall, or a long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // register write: setup then access
    task automatic apb_write(input t_reg_idx idx, input logic [BUS_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering and wait until every result has come back
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // one input transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_data_byte        <= data;
        i_first_of_message <= first;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // random permutation of the sixteen nibbles
    function automatic logic [KEY_W-1:0] random_grid();
        int perm [GRID_CELLS];
        int i, j, t;
        logic [KEY_W-1:0] grid;
        for (i = 0; i < GRID_CELLS; i++) perm[i] = i;
        for (i = GRID_CELLS - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (i = 0; i < GRID_CELLS; i++) grid[4*i +: 4] = 4'(perm[i]);
        return grid;
    endfunction

    // new random settings, then a run of messages
    task automatic run_segment(input bit with_hold, inout int count);
        logic [KEY_W-1:0] grid;
        logic [IV_W-1:0]  iv;
        logic             first;
        int sel, n, left;
        sel = $urandom_range(99);
        if (sel < 70) begin
            grid = random_grid();
        end else if (sel < 85) begin
            // one entry overwritten, usually leaving a duplicate
            grid = random_grid();
            grid[4*$urandom_range(15) +: 4] = 4'($urandom_range(15));
        end else begin
            grid = {$urandom, $urandom};
        end
        sel = $urandom_range(99);
        if (sel < 10) iv = '0;
        else if (sel < 20) iv = '1;
        else iv = $urandom;
        wait_results_drained();
        apb_write(REG_KEY_GRID, grid);
        apb_write(REG_DECRYPT, BUS_W'($urandom_range(1)));
        apb_write(REG_CHAINING, BUS_W'($urandom_range(99) < 75));
        apb_write(REG_INIT_VECTOR, BUS_W'(iv));
        if (with_hold) hold_request = HOLD_CYCLES;
        n = $urandom_range(30, 90);
        left = 0;
        repeat (n) begin
            // mostly well-formed messages, some stray message starts
            if (left == 0) begin
                left = $urandom_range(1, 12);
                first = 1'b1;
            end else begin
                first = 1'b0;
            end
            if ($urandom_range(99) < 10) first = 1'($urandom_range(1));
            send_byte(BYTE_W'($urandom_range(255)), first);
            left--;
            count++;
        end
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int phase, phase_sent;
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_data_byte        <= '0;
        i_first_of_message <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key is all zeros: bad key
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);

        // identity grid, plain encrypt: equal, row, column, rectangle cases
        wait_results_drained();
        apb_write(REG_KEY_GRID, GRID_IDENTITY);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h3c, 1'b0);

        // plain decrypt
        wait_results_drained();
        apb_write(REG_DECRYPT, BUS_W'(1'b1));
        send_byte(8'h01, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'hf0, 1'b0);

        // chained decrypt from the reset vector, past one block wrap
        wait_results_drained();
        apb_write(REG_CHAINING, BUS_W'(1'b1));
        send_byte(8'ha5, 1'b1);
        send_byte(8'h5a, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h12, 1'b0);

        // chained encrypt; a new vector only takes effect at a message start
        wait_results_drained();
        apb_write(REG_DECRYPT, BUS_W'(1'b0));
        apb_write(REG_INIT_VECTOR, BUS_W'(32'hffff_ffff));
        send_byte(8'h11, 1'b0);
        send_byte(8'h11, 1'b1);

        // repeated entry with a missing nibble, chained both ways
        wait_results_drained();
        apb_write(REG_KEY_GRID, 64'h0123_4567_89ab_cdee);
        send_byte(8'h7f, 1'b0);
        send_byte(8'he2, 1'b0);
        wait_results_drained();
        apb_write(REG_DECRYPT, BUS_W'(1'b1));
        send_byte(8'h33, 1'b0);

        // all-ones grid, zero vector, plain mode
        wait_results_drained();
        apb_write(REG_KEY_GRID, '1);
        apb_write(REG_INIT_VECTOR, '0);
        apb_write(REG_CHAINING, BUS_W'(1'b0));
        send_byte(8'h9c, 1'b1);

        // random phases with different idle mixes
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 19; recv_idle_pct = 49; end
                1: begin send_idle_pct = 49; recv_idle_pct = 19; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_sent = 0;
            while (phase_sent < ITEMS_PER_PHASE) run_segment(phase_sent == 0, phase_sent);
        end

        wait_results_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
